/* design/pbr_pkg.sv */
// Shared constants, types and command codes of the polynomial bisection root finder.
package pbr_pkg;

   // Field widths.
   localparam int FIX_W      = 24;  // signed Q8.16 interval points
   localparam int FRAC_BITS  = 16;
   localparam int COEF_W     = 16;
   localparam int NUM_COEFS  = 6;
   localparam int COEF_IDX_W = $clog2(NUM_COEFS);
   localparam int ITER_W     = 6;

   // Configuration port.
   localparam int CSR_IDX_W  = COEF_IDX_W;
   localparam int CSR_DATA_W = COEF_W;

   // Default step cap.
   localparam int MAX_ITERATIONS_DEF = 48;

   // Horner datapath widths. The product is saturated and shifted down by the
   // fraction width before the coefficient is added, so the accumulator never
   // leaves 49 signed bits and the 64-bit saturating add never clips.
   localparam int ACC_W    = 49;
   localparam int LO_W     = 24;                  // unsigned low part of the accumulator
   localparam int PART_W   = ACC_W - LO_W;        // multiplier operand width
   localparam int PROD_W   = PART_W + FIX_W;      // partial product width
   localparam int HI_SHIFT = LO_W - FRAC_BITS;
   localparam int SUM_W    = PROD_W + HI_SHIFT;   // shifted full product
   localparam int CLAMP_W  = 48;                  // 64-bit range after the shift

   typedef logic signed [FIX_W-1:0]  fix_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_COEF_0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COEF_1 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_COEF_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_COEF_3 = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_COEF_4 = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_COEF_5 = CSR_IDX_W'(5);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_MUL_LO,
      S_MUL_HI,
      S_SUM,
      S_ACC,
      S_SIGN,
      S_DECIDE,
      S_BISECT,
      S_DONE
   } ctl_state_type;

   typedef enum logic [1:0] {
      EV_A,
      EV_B,
      EV_C
   } eval_sel_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_LOAD,
      DP_INIT,
      DP_MUL_LO,
      DP_MUL_HI,
      DP_SUM,
      DP_ACC,
      DP_SIGN,
      DP_BISECT,
      DP_OUTPUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type    op;
      eval_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic last_term;  // the coefficient just added was coef_0
      logic cont;       // bracketed and the interval is still wider than the tolerance
      logic at_max;     // the step cap is reached
   } dp_status_type;

endpackage

/* design/pbr_channels.sv */
// Request and response channel interfaces of the polynomial bisection root finder.
interface pbr_req_if import pbr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   fix_type              interval_start;
   fix_type              interval_end;
   logic [FIX_W-1:0]     tolerance;

   modport source (output valid, output interval_start, output interval_end,
                   output tolerance, input ready);
   modport sink   (input valid, input interval_start, input interval_end,
                   input tolerance, output ready);
endinterface

interface pbr_rsp_if import pbr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   fix_type              root_estimate;
   fix_type              final_start;
   fix_type              final_end;
   logic [ITER_W-1:0]    iterations;
   logic                 bracketed;
   logic                 limit_hit;

   modport source (output valid, output root_estimate, output final_start,
                   output final_end, output iterations, output bracketed,
                   output limit_hit, input ready);
   modport sink   (input valid, input root_estimate, input final_start,
                   input final_end, input iterations, input bracketed,
                   input limit_hit, output ready);
endinterface

/* design/pbr_datapath.sv */
// Datapath: coefficients, interval registers, shared Horner multiplier and result register.
module pbr_datapath import pbr_pkg::*; #(
   parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  fix_type               in_start,
   input  fix_type               in_end,
   input  logic [FIX_W-1:0]      in_tol,
   output fix_type               out_root,
   output fix_type               out_start,
   output fix_type               out_end,
   output logic [ITER_W-1:0]     out_iterations,
   output logic                  out_bracketed,
   output logic                  out_limit_hit
);

   localparam int IT_W     = $clog2(MAX_ITERATIONS + 1);
   localparam int ITX_W    = (IT_W > ITER_W) ? IT_W : ITER_W;
   localparam int ITER_CAP = (1 << ITER_W) - 1;

   localparam logic signed [SUM_W-1:0] CLAMP_MAX =
      {{(SUM_W - CLAMP_W + 1){1'b0}}, {(CLAMP_W - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] CLAMP_MIN =
      {{(SUM_W - CLAMP_W + 1){1'b1}}, {(CLAMP_W - 1){1'b0}}};

   typedef struct packed {
      logic neg;
      logic nz;
   } sign_type;

   function automatic logic opposite(sign_type x, sign_type y);
      return x.nz & y.nz & (x.neg ^ y.neg);
   endfunction

   coef_type                 coef_ff [NUM_COEFS];
   fix_type                  a_ff;
   fix_type                  b_ff;
   logic [FIX_W-1:0]         tol_ff;
   fix_type                  x_ff;
   acc_type                  acc_ff;
   logic signed [PROD_W-1:0] plo_ff;
   logic signed [PROD_W-1:0] phi_ff;
   logic signed [SUM_W-1:0]  q_ff;
   logic [COEF_IDX_W-1:0]    k_ff;
   sign_type                 fa_ff;
   sign_type                 fc_ff;
   logic                     br_ff;
   logic [IT_W-1:0]          it_ff;

   fix_type                  root_ff;
   fix_type                  start_ff;
   fix_type                  end_ff;
   logic [ITER_W-1:0]        iter_ff;
   logic                     brk_ff;
   logic                     lim_ff;

   logic signed [FIX_W:0]     mid_sum;
   fix_type                   mid;
   logic signed [FIX_W:0]     diff;
   logic                      cont;
   logic                      at_max;
   logic signed [PART_W-1:0]  mul_a;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [SUM_W-1:0]   q_in;
   logic signed [CLAMP_W-1:0] clamped;
   acc_type                   acc_in;
   acc_type                   acc_init;
   sign_type                  acc_sign;
   logic [ITX_W-1:0]          it_wide;
   logic [ITER_W-1:0]         it_sat;

   // Midpoint, rounded toward minus infinity.
   assign mid_sum = {a_ff[FIX_W-1], a_ff} + {b_ff[FIX_W-1], b_ff};
   assign mid     = mid_sum[FIX_W:1];

   assign diff   = {b_ff[FIX_W-1], b_ff} - {a_ff[FIX_W-1], a_ff};
   assign cont   = br_ff & (diff > $signed({1'b0, tol_ff}));
   assign at_max = (it_ff >= IT_W'(MAX_ITERATIONS));

   assign status.last_term = (k_ff == '0);
   assign status.cont      = cont;
   assign status.at_max    = at_max;

   // One shared multiplier: the accumulator is taken in a low unsigned half and
   // a high signed half, in the MUL_LO and MUL_HI steps.
   always_comb begin
      if (cmd.op == DP_MUL_HI) begin
         mul_a = acc_ff[ACC_W-1:LO_W];
      end else begin
         mul_a = {1'b0, acc_ff[LO_W-1:0]};
      end
      mul_p = mul_a * x_ff;
   end

   // floor(product / 2^16) from the two partial products.
   assign q_in = (SUM_W'(phi_ff) <<< HI_SHIFT) + SUM_W'(plo_ff >>> FRAC_BITS);

   always_comb begin
      if (q_ff > CLAMP_MAX) begin
         clamped = CLAMP_MAX[CLAMP_W-1:0];
      end else if (q_ff < CLAMP_MIN) begin
         clamped = CLAMP_MIN[CLAMP_W-1:0];
      end else begin
         clamped = q_ff[CLAMP_W-1:0];
      end
   end

   assign acc_in   = ACC_W'(clamped) + (ACC_W'(coef_ff[k_ff]) <<< FRAC_BITS);
   assign acc_init = ACC_W'(coef_ff[NUM_COEFS-1]) <<< FRAC_BITS;

   assign acc_sign.neg = acc_ff[ACC_W-1];
   assign acc_sign.nz  = |acc_ff;

   assign it_wide = ITX_W'(it_ff);
   assign it_sat  = (it_wide > ITX_W'(ITER_CAP)) ? ITER_W'(ITER_CAP) : ITER_W'(it_wide);

   // Coefficient registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            REG_COEF_0: coef_ff[0] <= $signed(csr_wdata);
            REG_COEF_1: coef_ff[1] <= $signed(csr_wdata);
            REG_COEF_2: coef_ff[2] <= $signed(csr_wdata);
            REG_COEF_3: coef_ff[3] <= $signed(csr_wdata);
            REG_COEF_4: coef_ff[4] <= $signed(csr_wdata);
            REG_COEF_5: coef_ff[5] <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LOAD: begin
            a_ff   <= in_start;
            b_ff   <= in_end;
            tol_ff <= in_tol;
            it_ff  <= '0;
            br_ff  <= 1'b0;
         end
         DP_INIT: begin
            case (cmd.sel)
               EV_A:    x_ff <= a_ff;
               EV_B:    x_ff <= b_ff;
               default: x_ff <= mid;
            endcase
            acc_ff <= acc_init;
            k_ff   <= COEF_IDX_W'(NUM_COEFS - 2);
         end
         DP_MUL_LO: plo_ff <= mul_p;
         DP_MUL_HI: phi_ff <= mul_p;
         DP_SUM:    q_ff   <= q_in;
         DP_ACC: begin
            acc_ff <= acc_in;
            k_ff   <= k_ff - COEF_IDX_W'(1);
         end
         DP_SIGN: begin
            case (cmd.sel)
               EV_A:    fa_ff <= acc_sign;
               EV_B:    br_ff <= opposite(fa_ff, acc_sign);
               default: fc_ff <= acc_sign;
            endcase
         end
         DP_BISECT: begin
            it_ff <= it_ff + IT_W'(1);
            if (opposite(fc_ff, fa_ff)) begin
               b_ff <= mid;
            end else begin
               a_ff  <= mid;
               fa_ff <= fc_ff;
            end
         end
         DP_OUTPUT: begin
            root_ff  <= mid;
            start_ff <= a_ff;
            end_ff   <= b_ff;
            iter_ff  <= it_sat;
            brk_ff   <= br_ff;
            lim_ff   <= cont & at_max;
         end
         default: ;
      endcase
   end

   assign out_root       = root_ff;
   assign out_start      = start_ff;
   assign out_end        = end_ff;
   assign out_iterations = iter_ff;
   assign out_bracketed  = brk_ff;
   assign out_limit_hit  = lim_ff;

endmodule

/* design/pbr_controller.sv */
// Controller: sequences the Horner evaluations and bisection steps and owns the handshakes.
module pbr_controller import pbr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctl_state_type state_ff, state_in;
   eval_sel_type  eval_ff, eval_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         eval_ff      <= EV_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eval_ff      <= eval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      eval_in  = eval_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_INIT;
               eval_in  = EV_A;
            end
         end
         S_INIT:   state_in = S_MUL_LO;
         S_MUL_LO: state_in = S_MUL_HI;
         S_MUL_HI: state_in = S_SUM;
         S_SUM:    state_in = S_ACC;
         S_ACC:    state_in = status.last_term ? S_SIGN : S_MUL_LO;
         S_SIGN: begin
            unique case (eval_ff)
               EV_A: begin
                  eval_in  = EV_B;
                  state_in = S_INIT;
               end
               EV_B: begin
                  eval_in  = EV_C;
                  state_in = S_INIT;
               end
               default: state_in = S_DECIDE;
            endcase
         end
         S_DECIDE: state_in = (status.cont && !status.at_max) ? S_BISECT : S_DONE;
         S_BISECT: begin
            state_in = S_INIT;
            eval_in  = EV_C;
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd.sel      = eval_ff;
      cmd.op       = DP_IDLE;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = DP_LOAD;
            end
         end
         S_INIT:   cmd.op = DP_INIT;
         S_MUL_LO: cmd.op = DP_MUL_LO;
         S_MUL_HI: cmd.op = DP_MUL_HI;
         S_SUM:    cmd.op = DP_SUM;
         S_ACC:    cmd.op = DP_ACC;
         S_SIGN:   cmd.op = DP_SIGN;
         S_DECIDE: cmd.op = DP_IDLE;
         S_BISECT: cmd.op = DP_BISECT;
         S_DONE: begin
            if (slot_free) begin
               cmd.op       = DP_OUTPUT;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd.op = DP_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/polynomial_bisection_root_core.sv */
// Top level of the bisection root finder for a polynomial of degree up to five.
//
// Usage: write the six signed coefficients coef_0..coef_5 through the csr_ port
// (index i selects coef_i, indexes above five are ignored) while the block is
// idle. Each request transaction carries an interval start, an interval end and
// a tolerance in Q8.16; each one produces exactly one response transaction with
// the final midpoint, the final bounds, the step count and two flags.
//
// Sequence: one Horner evaluation runs a setup step (INIT), five terms each
// through MUL_LO, MUL_HI, SUM and ACC on the single shared 25 x 24 multiplier,
// and a sign capture. The three initial evaluations at start, end and midpoint
// come first, then the decision; every bisection step adds a bisect step, one
// midpoint evaluation and the next decision. One request is in work at a time,
// so a new one is accepted only after the previous result has gone to the
// output register.
//
// Reset clears the coefficients to zero and drops any pending response. If the
// receiver stalls, the finished response waits in the output register while the
// next request is accepted and computed; its result then waits for the register.
module polynomial_bisection_root_core import pbr_pkg::*; #(
   parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pbr_req_if.sink               req_ch,
   pbr_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller runs the sequence and the request and response handshakes.
   pbr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the interval, the coefficients and the response payload.
   pbr_datapath #(
      .MAX_ITERATIONS (MAX_ITERATIONS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .in_start       (req_ch.interval_start),
      .in_end         (req_ch.interval_end),
      .in_tol         (req_ch.tolerance),
      .out_root       (rsp_ch.root_estimate),
      .out_start      (rsp_ch.final_start),
      .out_end        (rsp_ch.final_end),
      .out_iterations (rsp_ch.iterations),
      .out_bracketed  (rsp_ch.bracketed),
      .out_limit_hit  (rsp_ch.limit_hit)
   );

endmodule

/* bench/polynomial_bisection_root_core_tb.sv */
// Self-checking testbench of the polynomial bisection root finder core.
`timescale 1ns / 100ps

module polynomial_bisection_root_core_tb import pbr_pkg::*; ();

   // Run shape.
   localparam int CLOCK_HALF        = 10;
   localparam int RESET_CYCLES      = 7;
   localparam int MAX_STEPS         = MAX_ITERATIONS_DEF;
   localparam int RANDOM_PER_PHASE  = 350;
   localparam int ITEMS_PER_SETTING = 70;
   localparam int PRESSURE_ITEMS    = 8;

   // The receiver hold-off is long enough for the block to finish one result,
   // accept and finish a second one even when both run the full step count,
   // and then refuse the third request until the hold ends.
   localparam int HOLD_CYCLES       = 3000;

   // A full 48-step search ends far inside this limit, so nothing legal goes this
   // long without a transaction on either channel.
   localparam int WATCHDOG_LIMIT    = 20000;
   localparam int SETTLE_CYCLES     = 1300;

   // Q8.16 and coefficient extremes.
   localparam fix_type          FIX_MIN  = {1'b1, {(FIX_W-1){1'b0}}};
   localparam fix_type          FIX_MAX  = {1'b0, {(FIX_W-1){1'b1}}};
   localparam fix_type          ONE      = fix_type'(1 << FRAC_BITS);
   localparam logic [FIX_W-1:0] TOL_MAX  = '1;
   localparam coef_type         COEF_MAX = 16'sh7FFF;
   localparam coef_type         COEF_MIN = 16'sh8000;

   // Bounds of the 64-bit saturating Horner accumulator.
   localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ACC_MIN = -ACC_MAX - 1;

   // Register map. Indexes past the coefficients are unused and must be ignored.
   localparam logic [CSR_IDX_W-1:0] COEF_REG [NUM_COEFS] = '{
      REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4, REG_COEF_5
   };
   localparam logic [CSR_IDX_W-1:0] SPARE_REG_LO = CSR_IDX_W'(NUM_COEFS);
   localparam logic [CSR_IDX_W-1:0] SPARE_REG_HI = '1;

   // One response transaction as the block should produce it.
   typedef struct packed {
      fix_type           root_estimate;
      fix_type           final_start;
      fix_type           final_end;
      logic [ITER_W-1:0] iterations;
      logic              bracketed;
      logic              limit_hit;
   } root_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pbr_req_if req_ch ();
   pbr_rsp_if rsp_ch ();

   // Mirror of the coefficient registers, updated on every coefficient write the bench makes.
   coef_type        coef_regs [NUM_COEFS];
   // Results predicted for accepted requests, oldest first.
   root_result_type pending_roots [$];

   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int holds_served   = 0;
   int idle_cycles    = 0;

   polynomial_bisection_root_core #(
      .MAX_ITERATIONS (MAX_STEPS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   function automatic longint clamp_acc(input logic signed [127:0] value);
      if (value > ACC_MAX) return ACC_MAX;
      if (value < ACC_MIN) return ACC_MIN;
      return longint'(value);
   endfunction

   // Horner evaluation in Q.16: each product is saturated to 64 bits, then
   // floored to 16 fractional bits, then the next coefficient is added with
   // saturation.
   function automatic longint horner_value(input longint x);
      logic signed [127:0] wide_acc;
      logic signed [127:0] wide_x;
      longint              acc;
      acc    = longint'(coef_regs[NUM_COEFS-1]) <<< FRAC_BITS;
      wide_x = 128'(x);
      for (int i = NUM_COEFS - 2; i >= 0; i--) begin
         wide_acc = 128'(acc);
         acc      = clamp_acc(wide_acc * wide_x) >>> FRAC_BITS;
         wide_acc = 128'(acc);
         acc      = clamp_acc(wide_acc + (longint'(coef_regs[i]) <<< FRAC_BITS));
      end
      return acc;
   endfunction

   function automatic int sign_of(input longint value);
      return (value > 0) ? 1 : ((value < 0) ? -1 : 0);
   endfunction

   // The whole search for one request, using the current coefficient mirror.
   function automatic root_result_type bisect_root(input fix_type start_pt,
                                                   input fix_type end_pt,
                                                   input logic [FIX_W-1:0] tol);
      root_result_type result;
      longint          lo;
      longint          hi;
      longint          mid;
      int              sign_lo;
      int              sign_hi;
      int              sign_mid;
      int              steps;
      logic            capped;
      lo       = longint'(start_pt);
      hi       = longint'(end_pt);
      mid      = (lo + hi) >>> 1;
      sign_lo  = sign_of(horner_value(lo));
      sign_hi  = sign_of(horner_value(hi));
      sign_mid = sign_of(horner_value(mid));
      steps    = 0;
      capped   = 1'b0;
      result.bracketed = (sign_lo * sign_hi < 0);
      if (result.bracketed) begin
         // A reversed interval has a negative width and never enters the loop.
         while (hi - lo > longint'(tol)) begin
            if (steps >= MAX_STEPS) begin
               capped = 1'b1;
               break;
            end
            steps++;
            // A zero at the midpoint does not differ in sign, so the lower end moves.
            if (sign_mid * sign_lo < 0) hi = mid;
            else lo = mid;
            mid      = (lo + hi) >>> 1;
            sign_lo  = sign_of(horner_value(lo));
            sign_mid = sign_of(horner_value(mid));
         end
      end
      result.root_estimate = fix_type'(mid);
      result.final_start   = fix_type'(lo);
      result.final_end     = fix_type'(hi);
      result.iterations    = (steps >= (1 << ITER_W)) ? '1 : ITER_W'(steps);
      result.limit_hit     = capped;
      return result;
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // Every task below starts and ends just after a falling edge, so each input
   // gets at most one assignment per time step.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
      if (index < NUM_COEFS) coef_regs[index] = coef_type'(data);
   endtask

   task automatic load_coefs(input coef_type c0, input coef_type c1, input coef_type c2,
                             input coef_type c3, input coef_type c4, input coef_type c5);
      coef_type values [NUM_COEFS];
      values = '{c0, c1, c2, c3, c4, c5};
      for (int i = 0; i < NUM_COEFS; i++) csr_write(COEF_REG[i], values[i]);
   endtask

   // Full-range sets saturate easily; small sets keep roots inside the Q8.16
   // range; the third style also trims the degree.
   task automatic randomize_coefs();
      int       style;
      int       degree;
      coef_type value;
      style  = $urandom_range(2);
      degree = $urandom_range(1, NUM_COEFS - 1);
      for (int i = 0; i < NUM_COEFS; i++) begin
         if (style == 0) value = coef_type'($urandom);
         else if (style == 1) value = coef_type'(int'($urandom_range(0, 32)) - 16);
         else value = (i > degree) ? '0 : coef_type'(int'($urandom_range(0, 512)) - 256);
         csr_write(COEF_REG[i], value);
      end
   endtask

   // Offers one request, waits for the handshake and records its prediction.
   task automatic send_interval(input fix_type start_pt, input fix_type end_pt,
                                input logic [FIX_W-1:0] tol);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.interval_start <= start_pt;
      req_ch.interval_end   <= end_pt;
      req_ch.tolerance      <= tol;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_roots.push_back(bisect_root(start_pt, end_pt, tol));
      @(negedge clock);
   endtask

   // Leaves the block idle: no request offered and every result returned.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (pending_roots.size() != 0) @(negedge clock);
   endtask

   function automatic fix_type clamp_fix(input longint value);
      if (value > FIX_MAX) return FIX_MAX;
      if (value < FIX_MIN) return FIX_MIN;
      return fix_type'(value);
   endfunction

   // Most requests are retried, for up to eight tries, until the ends bracket a root,
   // so the search itself gets exercised; the rest are raw 24-bit noise, including
   // reversed intervals and tolerances of any size.
   task automatic send_random_interval();
      fix_type          lo;
      fix_type          hi;
      longint           center;
      longint           half;
      logic [FIX_W-1:0] tol;
      int               tries;
      int               pick;
      if ($urandom_range(99) < 15) begin
         lo  = fix_type'($urandom);
         hi  = fix_type'($urandom);
         tol = FIX_W'($urandom);
      end else begin
         tries = 0;
         do begin
            if ($urandom_range(1) == 1) center = longint'(fix_type'($urandom));
            else center = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
            half  = longint'($urandom_range(1, 1 << $urandom_range(1, 22)));
            lo    = clamp_fix(center - half);
            hi    = clamp_fix(center + half);
            tries++;
         end while (tries < 8 && sign_of(horner_value(longint'(lo))) *
                    sign_of(horner_value(longint'(hi))) >= 0);
         // A tight tolerance runs the search into the step cap; those are slow,
         // so they stay rare.
         pick = $urandom_range(99);
         if (pick < 5) tol = FIX_W'($urandom_range(0, 3));
         else if (pick < 80) tol = (hi - lo) >> $urandom_range(1, 12);
         else tol = FIX_W'($urandom_range(0, TOL_MAX));
      end
      send_interval(lo, hi, tol);
   endtask

   // ---------------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------------

   // Ready toggles at random with the current stall rate. When the test asks
   // for a hold-off, ready stays low for a long counted stretch instead.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic check_field(input string name, input longint expected,
                              input longint actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                  expected, actual);
         error_count++;
      end
   endtask

   // Every response transaction is matched against the oldest prediction.
   always @(posedge clock) begin
      root_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_roots.size() == 0) begin
            $display("%0t: response transaction with no request outstanding", $time);
            error_count++;
         end else begin
            want = pending_roots.pop_front();
            check_field("root_estimate", longint'(want.root_estimate),
                        longint'(rsp_ch.root_estimate));
            check_field("final_start", longint'(want.final_start),
                        longint'(rsp_ch.final_start));
            check_field("final_end", longint'(want.final_end),
                        longint'(rsp_ch.final_end));
            check_field("iterations", longint'(want.iterations),
                        longint'(rsp_ch.iterations));
            check_field("bracketed", longint'(want.bracketed),
                        longint'(rsp_ch.bracketed));
            check_field("limit_hit", longint'(want.limit_hit),
                        longint'(rsp_ch.limit_hit));
         end
      end
   end

   // Ends a hung run: too many cycles without a transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Straight out of reset every coefficient is zero, so f is zero everywhere
   // and nothing can be bracketed. Writes to the unused indexes must not
   // change that.
   task automatic test_zero_polynomial();
      send_interval(FIX_MIN, FIX_MAX, '0);
      send_interval(FIX_MAX, FIX_MIN, TOL_MAX);
      wait_for_results();
      csr_write(SPARE_REG_LO, COEF_MAX);
      csr_write(SPARE_REG_HI, COEF_MIN);
      send_interval(-ONE, ONE, '0);
      wait_for_results();
   endtask

   // f(x) = x makes every special case easy to hit on purpose.
   task automatic test_linear_cases();
      load_coefs('0, coef_type'(1), '0, '0, '0, '0);
      send_interval(-ONE, ONE, FIX_W'(256));    // first midpoint is exactly the root
      send_interval(-ONE, ONE, '0);             // narrows to one LSB, then sticks at the cap
      send_interval(ONE, -ONE, '0);             // reversed interval, no step at all
      send_interval(ONE, fix_type'(ONE * 2), '0); // both ends positive, no bracket
      send_interval('0, ONE, '0);               // an end on the root is not a bracket
      send_interval(FIX_MIN, FIX_MAX, '0);      // widest interval, runs into the cap
      send_interval(FIX_MIN, FIX_MAX, TOL_MAX); // bracketed but already narrow enough
      send_interval(fix_type'(-1), fix_type'(2), '0);
      wait_for_results();
   endtask

   // x^3 - 2x has roots at zero and plus or minus the square root of two.
   task automatic test_cubic_roots();
      load_coefs('0, coef_type'(-2), '0, coef_type'(1), '0, '0);
      send_interval(ONE, fix_type'(ONE * 2), FIX_W'(1));
      send_interval(fix_type'(-ONE * 2), -ONE, FIX_W'(16));
      send_interval(fix_type'(-ONE / 2), fix_type'(ONE / 2), '0);
      wait_for_results();
   endtask

   // Extreme coefficients drive the Horner accumulator into saturation.
   task automatic test_extreme_coefficients();
      load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      send_interval(FIX_MIN, FIX_MAX, FIX_W'(256));
      send_interval(fix_type'(-ONE * 2), ONE, '0);
      wait_for_results();
      load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
      send_interval(FIX_MIN, FIX_MAX, FIX_W'(4096));
      send_interval('0, fix_type'(ONE * 2), FIX_W'(64));
      send_interval(fix_type'(-ONE * 3), fix_type'(ONE / 2), FIX_W'(2048));
      wait_for_results();
      load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      send_interval(FIX_MIN, FIX_MAX, FIX_W'(16));
      wait_for_results();
   endtask

   // Random traffic under one idling pattern, with a fresh coefficient set
   // loaded every 70 requests while the block is idle.
   task automatic test_random_phase(input int sender_pct, input int receiver_pct);
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
         if (n % ITEMS_PER_SETTING == 0) begin
            wait_for_results();
            randomize_coefs();
         end
         send_random_interval();
      end
      wait_for_results();
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the
   // output register and the compute stage both fill and the input stalls.
   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      repeat (PRESSURE_ITEMS) send_random_interval();
      wait_for_results();
   endtask

   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_ch.valid          = 1'b0;
      req_ch.interval_start = '0;
      req_ch.interval_end   = '0;
      req_ch.tolerance      = '0;
      foreach (coef_regs[i]) coef_regs[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_zero_polynomial();
      test_linear_cases();
      test_cubic_roots();
      test_extreme_coefficients();
      test_random_phase(0, 0);
      test_random_phase(57, 0);
      test_random_phase(0, 57);
      test_random_phase(34, 34);
      test_output_backpressure();

      // Anything the block sends from here on has no request behind it.
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* polynomial_bisection_root_core.f */
design/pbr_pkg.sv
design/pbr_channels.sv
design/pbr_datapath.sv
design/pbr_controller.sv
design/polynomial_bisection_root_core.sv
bench/polynomial_bisection_root_core_tb.sv
